// ===== rtl/ring_buffer_rounded_mean_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average unit
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_ROUNDED_MEAN_UNIT_MACROS_SVH
`define RING_BUFFER_ROUNDED_MEAN_UNIT_MACROS_SVH

// same-cycle implication
`define RBRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbrm_pkg
// Shared types and constants of the moving-average unit.
// ----------------------------------------------------------------------------
package rbrm_pkg;

  localparam int WLEN_BITS = 6;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_LOAD = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } rbrm_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic load;
    logic div_step;
    logic out_load;
  } rbrm_cmd_t;

  typedef struct packed {
    logic div_last;
  } rbrm_sts_t;

endpackage

// ===== rtl/rbrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbrm_ctrl
// Sequencer: sample transfer, ring update, serial divide, output register.
// ----------------------------------------------------------------------------
module rbrm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_valid_i,
  output logic               sample_ready_o,
  output logic               mean_valid_o,
  input  logic               mean_ready_i,
  input  rbrm_pkg::rbrm_sts_t sts_i,
  output rbrm_pkg::rbrm_cmd_t cmd_o
);
  import rbrm_pkg::*;

  rbrm_state_e state_q, state_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free;

  assign out_free = !out_vld_q || mean_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (mean_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign sample_ready_o = (state_q == ST_IDLE);
  assign mean_valid_o   = out_vld_q;

endmodule

// ===== rtl/rbrm_dp.sv =====
// ----------------------------------------------------------------------------
// rbrm_dp
// Ring memory, running sum, fill count and restoring serial divider.
// ----------------------------------------------------------------------------
module rbrm_dp #(
  parameter int DEPTH       = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbrm_pkg::WLEN_BITS-1:0]    cfg_wdata_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic [SAMPLE_BITS-1:0]            mean_o,
  input  rbrm_pkg::rbrm_cmd_t               cmd_i,
  output rbrm_pkg::rbrm_sts_t               sts_o
);
  import rbrm_pkg::*;

  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW       = $clog2(DEPTH + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(DEPTH);
  localparam int NUM_W    = SUM_W + 2;
  localparam int CW       = $clog2(NUM_W);
  localparam int DW       = WLEN_BITS + 1;
  localparam int WLEN_MAX = (1 << WLEN_BITS) - 1;
  localparam int RST_WL   = (DEPTH > WLEN_MAX) ? WLEN_MAX : DEPTH;

  logic [WLEN_BITS-1:0]   wl_q;
  logic [WLEN_BITS-1:0]   n_eff;
  logic [AW-1:0]          wp_q, wp_d;
  logic [AW:0]            wp_inc;
  logic [FW-1:0]          fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [NUM_W-1:0]       num_q;
  logic [DW-1:0]          rem_q;
  logic [DW-1:0]          den;
  logic [DW:0]            trial;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] quo_q;
  logic [CW-1:0]          cnt_q;
  logic [SAMPLE_BITS-1:0] mean_q;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_comb begin
    n_eff = wl_q;
    if (wl_q == '0) begin
      n_eff = WLEN_BITS'(1);
    end else if (32'(wl_q) > DEPTH) begin
      n_eff = WLEN_BITS'(DEPTH);
    end
  end

  assign wp_inc  = {1'b0, wp_q} + (AW + 1)'(1);
  assign old_val = (32'(wp_q) < 32'(fill_q)) ? rd_q : '0;

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (cmd_i.update) begin
      sum_d = sum_q - SUM_W'(old_val) + SUM_W'(smp_q);
      wp_d  = (32'(wp_inc) >= 32'(n_eff)) ? '0 : wp_inc[AW-1:0];
      if (32'(fill_q) < 32'(n_eff)) begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WLEN_BITS'(RST_WL);
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cfg_we_i) begin
      wl_q   <= cfg_wdata_i;
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[wp_q] <= smp_q;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[wp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= sample_i;
    end
  end

  // restoring divide of (2*sum + n) by 2*n, one quotient bit per cycle
  assign den   = {n_eff, 1'b0};
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= CW'(NUM_W - 1);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= {1'b0, sum_q, 1'b0} + NUM_W'(n_eff);
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quo_q <= SAMPLE_BITS'({quo_q, ge});
    end
    if (cmd_i.out_load) begin
      mean_q <= quo_q;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);
  assign mean_o         = mean_q;

endmodule

// ===== rtl/ring_buffer_rounded_mean_unit.sv =====
// A sample transfer is followed by a ring read, the ring update, the divider load, the bit-serial
// restoring divide that retires one quotient bit per cycle, and the output register load; no new
// sample is accepted before that load, which waits while a held mean is not yet taken.
// Reset (rst_ni, async, active low) sets window_len to DEPTH (at most 63) and empties the ring; a fill
// count marks unwritten entries as zero, so no clearing pass is needed. A window_len write
// empties the ring the same way.
// ----------------------------------------------------------------------------
// ring_buffer_rounded_mean_unit
// Moving average over a ring of window_len samples (zero acts as one, above DEPTH as DEPTH), mean rounded half up.
// ----------------------------------------------------------------------------
`include "ring_buffer_rounded_mean_unit_macros.svh"

module ring_buffer_rounded_mean_unit #(
  parameter int DEPTH       = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbrm_pkg::WLEN_BITS-1:0] cfg_wdata_i,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  output logic                           mean_valid_o,
  input  logic                           mean_ready_i,
  output logic [SAMPLE_BITS-1:0]         mean_o
);
  import rbrm_pkg::*;

  rbrm_cmd_t cmd;
  rbrm_sts_t sts;

  rbrm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .mean_valid_o   (mean_valid_o),
    .mean_ready_i   (mean_ready_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  rbrm_dp #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .mean_o      (mean_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `RBRM_ASSERT_NXT(a_busy_after_xfer, sample_valid_i && sample_ready_o, !sample_ready_o, "ready after sample transfer")
  `RBRM_ASSERT_NXT(a_out_load_valid, cmd.out_load, mean_valid_o, "result load lost")
  `RBRM_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0({cmd.accept, cmd.update, cmd.load, cmd.div_step, cmd.out_load}), "overlapping datapath commands")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Moving-average unit testbench
// Drives samples through a valid/ready channel in random bursts and drains
// means against a receiver with its own stall pattern and long hold-offs.
// A scoreboard keeps its own ring, write position and running sum, and
// predicts every rounded half-up mean. Window lengths, including zero and
// values above the depth, are written between phases while the unit idles.
// ----------------------------------------------------------------------------

class window_mean_model;
  localparam int DEPTH = 32;
  localparam int SBITS = 12;
  localparam int WBITS = rbrm_pkg::WLEN_BITS;

  logic [SBITS-1:0]               ring_q [DEPTH];
  logic [4:0]                     wr_pos;
  logic [16:0]                    run_sum;
  logic [rbrm_pkg::WLEN_BITS-1:0] wlen;
  logic [SBITS-1:0]               expected_means [$];
  int unsigned                    failures;
  int unsigned                    reported;

  function new();
    wlen     = WBITS'(DEPTH);
    failures = 0;
    reported = 0;
    clear_ring();
  endfunction

  function void clear_ring();
    foreach (ring_q[i]) ring_q[i] = '0;
    wr_pos  = '0;
    run_sum = '0;
  endfunction

  function void set_window(logic [rbrm_pkg::WLEN_BITS-1:0] v);
    wlen = v;
    clear_ring();
  endfunction

  // zero acts as one, anything above the depth as the depth
  function int unsigned active_len();
    if (wlen == 0) return 1;
    if (wlen > DEPTH) return DEPTH;
    return 32'(wlen);
  endfunction

  function void note_sample(logic [SBITS-1:0] s);
    int unsigned n;
    logic [18:0] num;
    n = active_len();
    if (wr_pos >= n) wr_pos = '0;
    run_sum = run_sum - ring_q[wr_pos] + s;
    ring_q[wr_pos] = s;
    if (int'(wr_pos) + 1 >= n) wr_pos = '0;
    else wr_pos = wr_pos + 1'b1;
    num = 19'({run_sum, 1'b0} + n);
    expected_means.push_back(SBITS'(num / (2 * n)));
  endfunction

  function void note_failure(string msg);
    failures++;
    if (reported < 10) begin
      reported++;
      $display("%s", msg);
    end
  endfunction

  function void check_mean(logic [SBITS-1:0] m);
    logic [SBITS-1:0] exp_m;
    if (expected_means.size() == 0) begin
      note_failure($sformatf("unexpected mean transfer: got %0d", m));
      return;
    end
    exp_m = expected_means.pop_front();
    if (m !== exp_m) begin
      note_failure($sformatf("mean mismatch: expected %0d, got %0d", exp_m, m));
    end
  endfunction

  function int pending();
    return expected_means.size();
  endfunction
endclass

module testbench;
  localparam int SAMPLE_BITS  = 12;
  localparam int WLEN_BITS    = rbrm_pkg::WLEN_BITS;
  localparam int SETTLE       = 30;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [WLEN_BITS-1:0]   cfg_wdata_i    = '0;
  logic                   sample_valid_i = 1'b0;
  logic                   sample_ready_o;
  logic [SAMPLE_BITS-1:0] sample_i       = '0;
  logic                   mean_valid_o;
  logic                   mean_ready_i   = 1'b0;
  logic [SAMPLE_BITS-1:0] mean_o;

  window_mean_model sb = new();
  int  n_random   = 0;
  int  burst_left = 0;
  logic hold_rx   = 1'b0;

  ring_buffer_rounded_mean_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .mean_valid_o   (mean_valid_o),
    .mean_ready_i   (mean_ready_i),
    .mean_o         (mean_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && mean_valid_o && mean_ready_i) sb.check_mean(mean_o);
  end

  // receiver stall pattern, switches among four random modes
  initial begin
    int mode;
    int left;
    logic rdy;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 7) == 0);
        default: rdy = (left % 5 == 0);
      endcase
      mean_ready_i <= !hold_rx && rdy;
    end
  end

  // long receiver hold-offs while the sender keeps offering
  initial begin
    int marks [3];
    marks = '{150, 550, 950};
    foreach (marks[i]) begin
      while (n_random < marks[i]) @(posedge clk_i);
      hold_rx = 1'b1;
      repeat (400) @(posedge clk_i);
      hold_rx = 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("[ring_buffer_rounded_mean_unit] ERROR");
    $finish;
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      sample_valid_i <= 1'b0;
    end
  endtask

  task automatic push_sample(logic [SAMPLE_BITS-1:0] s);
    @(negedge clk_i);
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
    sb.note_sample(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic write_window(logic [WLEN_BITS-1:0] v);
    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_window(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SMAX;
      2: return SAMPLE_BITS'($urandom_range(0, 15));
      3: return SAMPLE_BITS'(SMAX - $urandom_range(0, 15));
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [WLEN_BITS-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WLEN_BITS'($urandom_range(33, 63));
      2: return WLEN_BITS'(32);
      3: return WLEN_BITS'(1);
      default: return WLEN_BITS'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int count;
    int style;
    logic [SAMPLE_BITS-1:0] fixed;
    logic [SAMPLE_BITS-1:0] s;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    burst_left = $urandom_range(0, 40);

    // reset window of 32, unwritten entries read as zero
    push_sample(SMAX);
    push_sample(SMAX);
    push_sample(12'h000);
    push_sample(12'hAAA);
    push_sample(12'h555);
    push_sample(12'h001);
    push_sample(12'h800);
    write_window(1);
    push_sample(SMAX);
    push_sample(12'hAAA);
    push_sample(12'h555);
    write_window(0);
    push_sample(12'h007);
    push_sample(SMAX);
    write_window(63);
    push_sample(SMAX);
    push_sample(SMAX);
    write_window(33);
    push_sample(12'd100);
    // window of two: exact halves round up
    write_window(2);
    push_sample(12'd1);
    push_sample(12'd0);
    push_sample(12'd3);
    write_window(32);
    push_sample(12'd5);
    write_window(32);
    push_sample(12'd5);

    while (n_random < RANDOM_ITEMS) begin
      write_window(pick_window());
      style = $urandom_range(0, 3);
      fixed = rand_sample();
      count = $urandom_range(10, 120);
      repeat (count) begin
        case (style)
          0: s = SMAX;
          1: s = fixed;
          default: s = rand_sample();
        endcase
        push_sample(s);
        n_random++;
      end
    end

    @(negedge clk_i);
    sample_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("[ring_buffer_rounded_mean_unit] OK");
    end else begin
      $display("[ring_buffer_rounded_mean_unit] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rbrm_pkg.sv
rtl/rbrm_ctrl.sv
rtl/rbrm_dp.sv
rtl/ring_buffer_rounded_mean_unit.sv
tb/testbench.sv
